### design/lobsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lobsf_pkg
// Shared types, coefficient table and control program for the observer core.
// ----------------------------------------------------------------------------
package lobsf_pkg;

  localparam int IN_BITS   = 32;
  localparam int STEP_BITS = 17;
  localparam longint STEP_MAX = (longint'(1) << STEP_BITS) - 1;
  localparam int STEP_RESET_X10K = 100;
  localparam int SCALE10K  = 10000;

  localparam int NUM_EST   = 6;
  localparam int IDX_BITS  = 3;
  localparam int NUM_COEF  = 36;
  localparam int CIDX_BITS = 6;
  localparam int UCODE_LEN = 60;
  localparam int PC_BITS   = 6;

  typedef enum logic [2:0] {
    OP_INNOV,
    OP_CLR,
    OP_MAC,
    OP_STEP,
    OP_STORE,
    OP_COMMIT,
    OP_HOLD0,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    SRC_EST,
    SRC_U0,
    SRC_U1,
    SRC_E0,
    SRC_E1,
    SRC_ACC
  } src_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_e;

  typedef enum logic [2:0] {
    MPH_ISSUE,
    MPH_LO,
    MPH_HI,
    MPH_ROUND,
    MPH_ACC
  } mph_e;

  typedef struct packed {
    op_e                  op;
    src_e                 src;
    logic [IDX_BITS-1:0]  idx;
    logic [CIDX_BITS-1:0] cidx;
  } uinstr_t;

  // Nonzero matrix entries times 10000, in program order.
  localparam int COEF_X10K [NUM_COEF] = '{
    // row 0: A01, L00, L01
    10000, 50579, 773,
    // row 1: A10, A14, A15, L10, L11
    -45796, 1460, 1460, -31079, 3535,
    // row 2: A23, L20, L21
    10000, 966, 51477,
    // row 3: A32, A34, A35, L30, L31
    -9344, 5376, -5376, 4394, 5170,
    // row 4: A44, B40, L40, L41
    -22472, 206292, 109207, 21885,
    // row 5: A55, B51, L50, L51
    -22472, 206292, 115894, -41788,
    // feedback row 0
    1856, 10714, 35135, 16571, 2086, -1121,
    // feedback row 1
    1856, 10714, -35135, -16571, -1121, 2086
  };

  function automatic uinstr_t ui(op_e op, src_e src, int idx, int cidx);
    uinstr_t u;
    u.op   = op;
    u.src  = src;
    u.idx  = IDX_BITS'(idx);
    u.cidx = CIDX_BITS'(cidx);
    return u;
  endfunction

  // Zero matrix terms are left out: adding a zero product never changes a
  // saturated running sum.
  localparam uinstr_t UCODE [UCODE_LEN] = '{
    ui(OP_INNOV, SRC_EST, 0, 0),
    // row 0
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 1, 0),
    ui(OP_MAC,   SRC_E0,  0, 1),
    ui(OP_MAC,   SRC_E1,  0, 2),
    ui(OP_STEP,  SRC_ACC, 0, 0),
    ui(OP_STORE, SRC_EST, 0, 0),
    // row 1
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 0, 3),
    ui(OP_MAC,   SRC_EST, 4, 4),
    ui(OP_MAC,   SRC_EST, 5, 5),
    ui(OP_MAC,   SRC_E0,  0, 6),
    ui(OP_MAC,   SRC_E1,  0, 7),
    ui(OP_STEP,  SRC_ACC, 1, 0),
    ui(OP_STORE, SRC_EST, 1, 0),
    // row 2
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 3, 8),
    ui(OP_MAC,   SRC_E0,  0, 9),
    ui(OP_MAC,   SRC_E1,  0, 10),
    ui(OP_STEP,  SRC_ACC, 2, 0),
    ui(OP_STORE, SRC_EST, 2, 0),
    // row 3
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 2, 11),
    ui(OP_MAC,   SRC_EST, 4, 12),
    ui(OP_MAC,   SRC_EST, 5, 13),
    ui(OP_MAC,   SRC_E0,  0, 14),
    ui(OP_MAC,   SRC_E1,  0, 15),
    ui(OP_STEP,  SRC_ACC, 3, 0),
    ui(OP_STORE, SRC_EST, 3, 0),
    // row 4
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 4, 16),
    ui(OP_MAC,   SRC_U0,  0, 17),
    ui(OP_MAC,   SRC_E0,  0, 18),
    ui(OP_MAC,   SRC_E1,  0, 19),
    ui(OP_STEP,  SRC_ACC, 4, 0),
    ui(OP_STORE, SRC_EST, 4, 0),
    // row 5
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 5, 20),
    ui(OP_MAC,   SRC_U1,  0, 21),
    ui(OP_MAC,   SRC_E0,  0, 22),
    ui(OP_MAC,   SRC_E1,  0, 23),
    ui(OP_STEP,  SRC_ACC, 5, 0),
    ui(OP_STORE, SRC_EST, 5, 0),
    ui(OP_COMMIT, SRC_EST, 0, 0),
    // feedback row 0
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 0, 24),
    ui(OP_MAC,   SRC_EST, 1, 25),
    ui(OP_MAC,   SRC_EST, 2, 26),
    ui(OP_MAC,   SRC_EST, 3, 27),
    ui(OP_MAC,   SRC_EST, 4, 28),
    ui(OP_MAC,   SRC_EST, 5, 29),
    ui(OP_HOLD0, SRC_EST, 0, 0),
    // feedback row 1
    ui(OP_CLR,   SRC_EST, 0, 0),
    ui(OP_MAC,   SRC_EST, 0, 30),
    ui(OP_MAC,   SRC_EST, 1, 31),
    ui(OP_MAC,   SRC_EST, 2, 32),
    ui(OP_MAC,   SRC_EST, 3, 33),
    ui(OP_MAC,   SRC_EST, 4, 34),
    ui(OP_MAC,   SRC_EST, 5, 35),
    ui(OP_EMIT,  SRC_EST, 0, 0)
  };

endpackage
`default_nettype wire

### design/luenberger_observer_state_feedback_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// luenberger_observer_state_feedback_core
// Fixed-point Luenberger observer with state feedback, run by a microcoded
// sequencer over one shared multiply/round/saturate/accumulate datapath.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  input    | in_valid_i / in_ready_o | meas_first_i, meas_second_i,
//           |                         | drive_in_first_i, drive_in_second_i
//  output   | out_valid_o/out_ready_i | drive_out_first_o, drive_out_second_o
//  config   | cfg_we_i                | cfg_wdata_i (step size)
//
//  One transaction runs 42 products through the shared multiplier plus 18
//  other program steps between acceptance and the result.
//  The next transaction is accepted the cycle after the result is loaded.
//  A result waiting in the output register holds the last program step only.
//  Reset clears the estimate and loads the default step size.
// ----------------------------------------------------------------------------
module luenberger_observer_state_feedback_core
  import lobsf_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [IN_BITS-1:0]   meas_first_i,
  input  logic signed [IN_BITS-1:0]   meas_second_i,
  input  logic signed [IN_BITS-1:0]   drive_in_first_i,
  input  logic signed [IN_BITS-1:0]   drive_in_second_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [IN_BITS-1:0]   drive_out_first_o,
  output logic signed [IN_BITS-1:0]   drive_out_second_o,
  input  logic                        cfg_we_i,
  input  logic        [STEP_BITS-1:0] cfg_wdata_i
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int MB  = (F + 5 > STEP_BITS) ? F + 5 : STEP_BITS;
  localparam int HA  = (W + 1) / 2;
  localparam int PW  = W + MB;
  localparam int PPW = HA + MB;
  localparam int RW  = PW + 1;
  localparam int QW  = RW - F;
  localparam int XW  = W + IN_BITS;

  localparam logic [W-1:0]  WMAX     = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN     = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] LIM_POS  = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG  = LIM_POS + 1'b1;
  localparam logic [RW-1:0] RND_HALF = RW'(1) << (F - 1);

  typedef logic [MB-1:0] coef_mag_t [NUM_COEF];

  function automatic logic [MB-1:0] fix_mag(input int c);
    longint m;
    m = (c < 0) ? -longint'(c) : longint'(c);
    return MB'(((m << FRAC_BITS) + SCALE10K / 2) / SCALE10K);
  endfunction

  function automatic coef_mag_t coef_table();
    coef_mag_t t;
    for (int i = 0; i < NUM_COEF; i++) begin
      t[i] = fix_mag(COEF_X10K[i]);
    end
    return t;
  endfunction

  function automatic logic [STEP_BITS-1:0] step_reset_val();
    longint r;
    r = ((longint'(STEP_RESET_X10K) << FRAC_BITS) + SCALE10K / 2) / SCALE10K;
    if (r > STEP_MAX) begin
      r = STEP_MAX;
    end
    return STEP_BITS'(r);
  endfunction

  localparam coef_mag_t COEF_MAG = coef_table();
  localparam logic [STEP_BITS-1:0] STEP_RESET = step_reset_val();

  // Clamp a sign-extended value to the word range.
  function automatic logic [W-1:0] sat_wide(input logic [XW-1:0] v);
    logic [IN_BITS:0] top;
    top = v[XW-1:W-1];
    if (&top || ~|top) begin
      return v[W-1:0];
    end else if (v[XW-1]) begin
      return WMIN;
    end else begin
      return WMAX;
    end
  endfunction

  // Control and state
  seq_e                 seq_q, seq_d;
  logic [PC_BITS-1:0]   pc_q, pc_d;
  mph_e                 phase_q, phase_d;
  logic                 out_valid_q, out_valid_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic [W-1:0]         est_q [NUM_EST];
  logic [W-1:0]         est_d [NUM_EST];

  // Datapath payload
  logic [W-1:0]       nx_q [NUM_EST];
  logic [W-1:0]       nx_d [NUM_EST];
  logic [W-1:0]       y0_q, y0_d, y1_q, y1_d, u0_q, u0_d, u1_q, u1_d;
  logic [W-1:0]       e0_q, e0_d, e1_q, e1_d;
  logic [W-1:0]       acc_q, acc_d, q_q, q_d, res0_q, res0_d;
  logic [W-1:0]       ma_q, ma_d;
  logic [MB-1:0]      mb_q, mb_d;
  logic               neg_q, neg_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [IN_BITS-1:0] out_first_q, out_first_d, out_second_q, out_second_d;

  // Combinational
  uinstr_t        cur;
  logic           in_accept;
  logic           emit_go;
  logic [W-1:0]   a_val;
  logic           coef_neg;
  logic [HA-1:0]  chunk;
  logic [PPW-1:0] pp;
  logic [RW-1:0]  rnd;
  logic [QW-1:0]  qv, lim, qs;
  logic [W-1:0]   q_val;
  logic [W:0]     acc_sum, diff0, diff1;
  logic [W-1:0]   acc_sat, neg_acc;

  assign cur       = UCODE[pc_q];
  assign in_accept = in_valid_i & in_ready_o;

  // Sequencer: next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (in_accept) begin
          seq_d = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (emit_go) begin
          seq_d = SEQ_IDLE;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    emit_go    = 1'b0;
    case (seq_q)
      SEQ_IDLE: in_ready_o = 1'b1;
      SEQ_RUN: begin
        // hold on the last step while the output register is still occupied
        emit_go = (cur.op == OP_EMIT) && (!out_valid_q || out_ready_i);
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // Operand source
  always_comb begin
    case (cur.src)
      SRC_EST: a_val = est_q[cur.idx];
      SRC_U0:  a_val = u0_q;
      SRC_U1:  a_val = u1_q;
      SRC_E0:  a_val = e0_q;
      SRC_E1:  a_val = e1_q;
      SRC_ACC: a_val = acc_q;
      default: a_val = '0;
    endcase
  end

  assign coef_neg = (COEF_X10K[cur.cidx] < 0);

  // Shared multiplier: one half of the magnitude per cycle
  assign chunk = (phase_q == MPH_LO) ? ma_q[HA-1:0] : HA'(ma_q[W-1:HA]);
  assign pp    = PPW'(chunk) * PPW'(mb_q);

  // Round to nearest, ties away from zero, then clamp the magnitude
  assign rnd   = {1'b0, prod_q} + RND_HALF;
  assign qv    = rnd[RW-1:F];
  assign lim   = neg_q ? LIM_NEG : LIM_POS;
  assign qs    = (qv > lim) ? lim : qv;
  assign q_val = neg_q ? W'(-qs[W-1:0]) : qs[W-1:0];

  assign acc_sum = {acc_q[W-1], acc_q} + {q_q[W-1], q_q};
  assign acc_sat = sat_wide({{(IN_BITS-1){acc_sum[W]}}, acc_sum});
  assign neg_acc = (acc_q == WMIN) ? WMAX : W'(-acc_q);
  assign diff0   = {y0_q[W-1], y0_q} - {est_q[0][W-1], est_q[0]};
  assign diff1   = {y1_q[W-1], y1_q} - {est_q[2][W-1], est_q[2]};

  // Datapath driven by the current control word
  always_comb begin
    pc_d    = pc_q;
    phase_d = phase_q;
    est_d   = est_q;
    nx_d    = nx_q;
    y0_d    = y0_q;
    y1_d    = y1_q;
    u0_d    = u0_q;
    u1_d    = u1_q;
    e0_d    = e0_q;
    e1_d    = e1_q;
    acc_d   = acc_q;
    q_d     = q_q;
    res0_d  = res0_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    neg_d   = neg_q;
    prod_d  = prod_q;

    if (in_accept) begin
      y0_d    = sat_wide({{W{meas_first_i[IN_BITS-1]}}, meas_first_i});
      y1_d    = sat_wide({{W{meas_second_i[IN_BITS-1]}}, meas_second_i});
      u0_d    = sat_wide({{W{drive_in_first_i[IN_BITS-1]}}, drive_in_first_i});
      u1_d    = sat_wide({{W{drive_in_second_i[IN_BITS-1]}}, drive_in_second_i});
      pc_d    = '0;
      phase_d = MPH_ISSUE;
    end else if (seq_q == SEQ_RUN) begin
      case (cur.op)
        OP_INNOV: begin
          e0_d = sat_wide({{(IN_BITS-1){diff0[W]}}, diff0});
          e1_d = sat_wide({{(IN_BITS-1){diff1[W]}}, diff1});
          pc_d = pc_q + 1'b1;
        end
        OP_CLR: begin
          acc_d = '0;
          pc_d  = pc_q + 1'b1;
        end
        OP_MAC, OP_STEP: begin
          case (phase_q)
            MPH_ISSUE: begin
              ma_d = a_val[W-1] ? W'(-a_val) : a_val;
              if (cur.op == OP_STEP) begin
                // d times step, added onto the old estimate of this row
                mb_d  = MB'(step_q);
                neg_d = a_val[W-1];
                acc_d = est_q[cur.idx];
              end else begin
                mb_d  = COEF_MAG[cur.cidx];
                neg_d = a_val[W-1] ^ coef_neg;
              end
              phase_d = MPH_LO;
            end
            MPH_LO: begin
              prod_d  = PW'(pp);
              phase_d = MPH_HI;
            end
            MPH_HI: begin
              prod_d  = prod_q + (PW'(pp) << HA);
              phase_d = MPH_ROUND;
            end
            MPH_ROUND: begin
              q_d     = q_val;
              phase_d = MPH_ACC;
            end
            MPH_ACC: begin
              acc_d   = acc_sat;
              phase_d = MPH_ISSUE;
              pc_d    = pc_q + 1'b1;
            end
            default: phase_d = MPH_ISSUE;
          endcase
        end
        OP_STORE: begin
          nx_d[cur.idx] = acc_q;
          pc_d          = pc_q + 1'b1;
        end
        OP_COMMIT: begin
          est_d = nx_q;
          pc_d  = pc_q + 1'b1;
        end
        OP_HOLD0: begin
          res0_d = neg_acc;
          pc_d   = pc_q + 1'b1;
        end
        OP_EMIT: begin
          if (emit_go) begin
            pc_d = '0;
          end
        end
        default: pc_d = '0;
      endcase
    end
  end

  // Output register and step size
  always_comb begin
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    step_d       = cfg_we_i ? cfg_wdata_i : step_q;
    if (emit_go) begin
      out_valid_d  = 1'b1;
      out_first_d  = IN_BITS'($signed(res0_q));
      out_second_d = IN_BITS'($signed(neg_acc));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      pc_q        <= '0;
      phase_q     <= MPH_ISSUE;
      out_valid_q <= 1'b0;
      step_q      <= STEP_RESET;
      est_q       <= '{default: '0};
    end else begin
      seq_q       <= seq_d;
      pc_q        <= pc_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      est_q       <= est_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q         <= nx_d;
    y0_q         <= y0_d;
    y1_q         <= y1_d;
    u0_q         <= u0_d;
    u1_q         <= u1_d;
    e0_q         <= e0_d;
    e1_q         <= e1_d;
    acc_q        <= acc_d;
    q_q          <= q_d;
    res0_q       <= res0_d;
    ma_q         <= ma_d;
    mb_q         <= mb_d;
    neg_q        <= neg_d;
    prod_q       <= prod_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

  assign out_valid_o        = out_valid_q;
  assign drive_out_first_o  = out_first_q;
  assign drive_out_second_o = out_second_q;

endmodule
`default_nettype wire

### test/observer_drive_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// observer_drive_checker
// Watches the input, output and step-size ports of the observer core. On each
// accepted measurement it advances its own saturating Q16.16 observer and
// queues the feedback drive it expects. Each accepted result is compared,
// field by field, with the oldest queued drive.
// ----------------------------------------------------------------------------
module observer_drive_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] meas_first_i,
  input  logic signed [31:0] meas_second_i,
  input  logic signed [31:0] drive_in_first_i,
  input  logic signed [31:0] drive_in_second_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] drive_out_first_i,
  input  logic signed [31:0] drive_out_second_i,
  input  logic               cfg_we_i,
  input  logic        [16:0] cfg_wdata_i,
  output int                 mismatch_count_o,
  output int                 pending_count_o,
  output int                 checked_count_o
);

  localparam int     FRAC       = 16;
  localparam int     EST_LEN    = 6;
  localparam int     REPORT_MAX = 10;
  localparam int     RESET_STEP_X10K = 100;
  localparam longint WORD_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WORD_MIN   = -WORD_MAX - 1;

  // Plant, input, observer gain and feedback matrices, times 10000, row major.
  localparam int DRIFT_X10K [36] = '{
    0,      10000, 0,     0,     0,      0,
    -45796, 0,     0,     0,     1460,   1460,
    0,      0,     0,     10000, 0,      0,
    0,      0,     -9344, 0,     5376,   -5376,
    0,      0,     0,     0,     -22472, 0,
    0,      0,     0,     0,     0,      -22472
  };
  localparam int INPUT_X10K [12] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 206292, 0, 0, 206292
  };
  localparam int GAIN_X10K [12] = '{
    50579, 773, -31079, 3535, 966, 51477,
    4394, 5170, 109207, 21885, 115894, -41788
  };
  localparam int FEEDBACK_X10K [12] = '{
    1856, 10714, 35135,  16571,  2086,  -1121,
    1856, 10714, -35135, -16571, -1121, 2086
  };

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } drive_pair_t;

  longint      est_q [EST_LEN];
  longint      step_q;
  drive_pair_t expected_drives [$];
  drive_pair_t want;

  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  // Decimal constant to Q16.16, round half away from zero.
  function automatic longint coef_q(int x10k);
    longint mag;
    mag = (x10k < 0) ? -longint'(x10k) : longint'(x10k);
    mag = ((mag <<< FRAC) + 5000) / 10000;
    return (x10k < 0) ? -mag : mag;
  endfunction

  // Exact product, round magnitude half away from zero, saturate.
  function automatic longint mul_round(longint a, longint b);
    bit          neg;
    bit   [63:0] ua;
    bit   [63:0] ub;
    bit   [63:0] mag;
    bit   [63:0] lim;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    mag = (ua * ub + (64'd1 << (FRAC - 1))) >> FRAC;
    lim = neg ? 64'(WORD_MAX) + 64'd1 : 64'(WORD_MAX);
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic drive_pair_t advance_observer(longint y0, longint y1,
                                                   longint u0, longint u1);
    longint      innov [2];
    longint      drv_in [2];
    longint      nxt [EST_LEN];
    longint      acc;
    drive_pair_t drv;
    drv_in[0] = u0;
    drv_in[1] = u1;
    innov[0]  = clamp_word(y0 - est_q[0]);
    innov[1]  = clamp_word(y1 - est_q[2]);
    for (int r = 0; r < EST_LEN; r++) begin
      acc = 0;
      for (int c = 0; c < EST_LEN; c++)
        acc = add_sat(acc, mul_round(coef_q(DRIFT_X10K[r*EST_LEN+c]), est_q[c]));
      for (int c = 0; c < 2; c++)
        acc = add_sat(acc, mul_round(coef_q(INPUT_X10K[r*2+c]), drv_in[c]));
      for (int c = 0; c < 2; c++)
        acc = add_sat(acc, mul_round(coef_q(GAIN_X10K[r*2+c]), innov[c]));
      nxt[r] = add_sat(est_q[r], mul_round(acc, step_q));
    end
    for (int r = 0; r < EST_LEN; r++) est_q[r] = nxt[r];
    for (int k = 0; k < 2; k++) begin
      acc = 0;
      for (int c = 0; c < EST_LEN; c++)
        acc = add_sat(acc, mul_round(coef_q(FEEDBACK_X10K[k*EST_LEN+c]), nxt[c]));
      acc = clamp_word(-acc);
      if (k == 0) drv.first = acc[31:0];
      else        drv.second = acc[31:0];
    end
    return drv;
  endfunction

  task automatic report(string what, logic [31:0] exp_val, logic [31:0] act_val);
    if (mismatch_count_o < REPORT_MAX)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_val, act_val);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EST_LEN; i++) est_q[i] = 0;
      step_q = coef_q(RESET_STEP_X10K);
      expected_drives.delete();
      pending_count_o = 0;
    end else begin
      // Check results before queueing, so an empty queue is caught.
      if (out_valid_i && out_ready_i) begin
        checked_count_o++;
        if (expected_drives.size() == 0) begin
          report("unexpected result, first drive", '0, drive_out_first_i);
        end else begin
          want = expected_drives.pop_front();
          if (want.first !== drive_out_first_i)
            report("drive_out_first", want.first, drive_out_first_i);
          if (want.second !== drive_out_second_i)
            report("drive_out_second", want.second, drive_out_second_i);
        end
      end
      if (cfg_we_i) step_q = longint'(cfg_wdata_i);
      if (in_valid_i && in_ready_i)
        expected_drives.push_back(advance_observer(longint'(meas_first_i),
                                                   longint'(meas_second_i),
                                                   longint'(drive_in_first_i),
                                                   longint'(drive_in_second_i)));
      pending_count_o = expected_drives.size();
    end
  end

endmodule
`default_nettype wire

### test/luenberger_observer_state_feedback_core_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// luenberger_observer_state_feedback_core_test
// Drives measurement ticks into the observer core under a range of step sizes,
// from zero to the top of the register, with random gaps on both channels and
// one long output stall. A side checker predicts and compares every drive.
// ----------------------------------------------------------------------------
module luenberger_observer_state_feedback_core_test;
  import lobsf_pkg::*;

  localparam int HOLD_CYCLES = 1500;
  localparam int STALL_LIMIT = 6000;
  localparam int TAIL_CYCLES = 300;
  localparam int NUM_PHASES  = 7;
  localparam int RANDOM_STEP = -1;
  localparam int PRESSURE_PHASE = 2;
  localparam int STEADY_PHASE   = 4;

  localparam int PHASE_STEP [NUM_PHASES] = '{0, 131071, 1, 65536, 6554, RANDOM_STEP, 655};
  localparam int PHASE_LEN  [NUM_PHASES] = '{100, 100, 150, 150, 250, 150, 200};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [IN_BITS-1:0]   meas_first = '0;
  logic signed [IN_BITS-1:0]   meas_second = '0;
  logic signed [IN_BITS-1:0]   drive_in_first = '0;
  logic signed [IN_BITS-1:0]   drive_in_second = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [IN_BITS-1:0]   drive_out_first;
  logic signed [IN_BITS-1:0]   drive_out_second;
  logic                        cfg_we = 1'b0;
  logic        [STEP_BITS-1:0] cfg_wdata = '0;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int ticks_sent = 0;
  int steps_written = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_served = 1'b0;
  bit steady = 1'b0;

  logic [31:0] traj_meas_first = '0;
  logic [31:0] traj_meas_second = '0;
  logic [31:0] traj_drive_first = '0;
  logic [31:0] traj_drive_second = '0;

  luenberger_observer_state_feedback_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .meas_first_i      (meas_first),
    .meas_second_i     (meas_second),
    .drive_in_first_i  (drive_in_first),
    .drive_in_second_i (drive_in_second),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .drive_out_first_o (drive_out_first),
    .drive_out_second_o(drive_out_second),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata)
  );

  observer_drive_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .meas_first_i      (meas_first),
    .meas_second_i     (meas_second),
    .drive_in_first_i  (drive_in_first),
    .drive_in_second_i (drive_in_second),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .drive_out_first_i (drive_out_first),
    .drive_out_second_i(drive_out_second),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count),
    .checked_count_o   (checked_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      hold_served <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      out_ready   <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Full-width random word scaled down by a random shift, sometimes an extreme.
  function automatic logic [31:0] pick_value();
    int raw;
    if ($urandom_range(99) < 5) return pick_extreme();
    raw = $urandom();
    return raw >>> $urandom_range(0, 24);
  endfunction

  // Small random walk step, saturated to the word.
  function automatic logic [31:0] drift(logic [31:0] v);
    int     delta;
    longint sum;
    delta = $urandom();
    sum   = longint'($signed(v)) + longint'(delta >>> 19);
    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
    return sum[31:0];
  endfunction

  task automatic offer_tick(logic [31:0] m1, logic [31:0] m2,
                            logic [31:0] d1, logic [31:0] d2);
    if (!steady && $urandom_range(99) < 15) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 239)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid        <= 1'b1;
    meas_first      <= m1;
    meas_second     <= m2;
    drive_in_first  <= d1;
    drive_in_second <= d2;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Mostly smooth trajectories, with noise and occasional fresh vectors.
  task automatic run_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        traj_meas_first   = drift(traj_meas_first);
        traj_meas_second  = drift(traj_meas_second);
        traj_drive_first  = drift(traj_drive_first);
        traj_drive_second = drift(traj_drive_second);
        offer_tick(traj_meas_first, traj_meas_second, traj_drive_first, traj_drive_second);
      end else if (sel < 95) begin
        offer_tick(pick_value(), pick_value(), pick_value(), pick_value());
      end else begin
        traj_meas_first   = pick_value();
        traj_meas_second  = pick_value();
        traj_drive_first  = pick_value();
        traj_drive_second = pick_value();
        offer_tick(traj_meas_first, traj_meas_second, traj_drive_first, traj_drive_second);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    int step_val;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at the reset step size.
    offer_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_tick(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_tick(32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000);
    offer_tick(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    offer_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    offer_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    offer_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    offer_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    offer_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_tick(32'h0003_2000, 32'hFFFE_8000, 32'h0000_4000, 32'hFFFF_C000);
    offer_tick(32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000);
    offer_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    run_random(200);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      step_val = (PHASE_STEP[p] == RANDOM_STEP) ? $urandom_range(1, 65536) : PHASE_STEP[p];
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_wdata <= STEP_BITS'(step_val);
      @(negedge clk_i);
      cfg_we    <= 1'b0;
      steps_written++;
      steady = (p == STEADY_PHASE);
      // Stall the output long enough that the core backs up into its input.
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      run_random(PHASE_LEN[p]);
      drain();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Sent %0d observer ticks under %0d step sizes (reset value, zero, full scale).",
             ticks_sent, steps_written + 1);
    $display("Compared %0d feedback drive pairs, %0d mismatches, %0d left pending.",
             checked_count, mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
